@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

@@ sv/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// ffca_pkg
// Types and constants shared by the first-fit chunk allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int PAGES_DEF      = 4;
  localparam int MIN_UNIT_DEF   = 8;
  localparam int MAX_CHUNKS_DEF = 64;

  localparam int OFFSET_W = 14;
  localparam int REQ_W    = 15;
  localparam int END_W    = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic [REQ_W-1:0]    request_bytes;
    logic [OFFSET_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] chunk_offset;
  } rsp_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] start;
    logic [REQ_W-1:0]    length;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [END_W-1:0] pos;
    logic [END_W-1:0] tail;
  } tok_t;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } shift_t;

  typedef struct packed {
    shift_t mode;
    logic   append;
    entry_t fill;
  } cmd_t;

endpackage

@@ sv/first_fit_chunk_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_core
// First-fit allocator over a region of PAGES*PAGE_BYTES bytes, with the chunk
// table held as a row of cells that a search token walks one slot a cycle.
// ----------------------------------------------------------------------------
// Clear and the unused code answer straight from S_IDLE; free launches the
// token walk at once; allocate first registers the quotient in S_CHECK, then
// tests the size and table room and launches the walk, or ends on a bad size
// or a full table. One request at a time, and the next transfer is taken at
// the edge that ends the result cycle.
// Results cannot be stalled. Reset empties the table; entries are not cleared.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator_core #(
  parameter int PAGE_BYTES = ffca_pkg::PAGE_BYTES_DEF,
  parameter int PAGES      = ffca_pkg::PAGES_DEF,
  parameter int MIN_UNIT   = ffca_pkg::MIN_UNIT_DEF,
  parameter int MAX_CHUNKS = ffca_pkg::MAX_CHUNKS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ffca_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output ffca_pkg::rsp_t response
);
  import ffca_pkg::*;

  localparam int REGION = PAGES * PAGE_BYTES;
  localparam int RGW    = $clog2(REGION + 1);
  localparam int SW     = (RGW > END_W + 1) ? RGW : END_W + 1;
  localparam int CW     = $clog2(MAX_CHUNKS + 1);
  localparam int QS     = REQ_W + 7;
  localparam int PW     = REQ_W + QS + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << QS) + 64'(MIN_UNIT) - 64'd1) / 64'(MIN_UNIT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_t;

  state_t           state;
  logic [CW-1:0]    count;
  req_t             req_q;
  logic [REQ_W-1:0] quot;
  logic             check_step;
  tok_t             launch;
  cmd_t             cmd;

  tok_t             tok_chain [MAX_CHUNKS+1];
  entry_t           ent       [MAX_CHUNKS];
  entry_t           lower_ent [MAX_CHUNKS];
  entry_t           upper_ent [MAX_CHUNKS];

  logic [PW-1:0]    prod;
  logic [REQ_W-1:0] quot_back;
  tok_t             tok_last;
  logic [END_W-1:0] pos;
  logic [SW-1:0]    pos_sum;
  logic             no_space;

  assign busy      = (state != S_IDLE);
  assign tok_chain[0] = launch;
  assign tok_last  = tok_chain[MAX_CHUNKS];

  // The quotient by the minimum unit comes from a reciprocal multiply; the
  // size is a multiple exactly when the quotient times the unit gives it back.
  assign prod      = PW'(req_q.request_bytes) * PW'(RECIP);
  assign quot_back = quot * REQ_W'(MIN_UNIT);

  assign pos      = tok_last.found ? tok_last.pos : tok_last.tail;
  assign pos_sum  = SW'(pos) + SW'(req_q.request_bytes);
  assign no_space = !tok_last.found && (pos_sum > SW'(REGION));

  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lower_ent[i] = '0;
    end else begin : g_mid
      assign lower_ent[i] = ent[i-1];
    end
    if (i == MAX_CHUNKS - 1) begin : g_last
      assign upper_ent[i] = '0;
    end else begin : g_inner
      assign upper_ent[i] = ent[i+1];
    end

    ffca_cell #(
      .IDX        (i),
      .MAX_CHUNKS (MAX_CHUNKS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .request (req_q),
      .cmd     (cmd),
      .lower   (lower_ent[i]),
      .upper   (upper_ent[i]),
      .tok_in  (tok_chain[i]),
      .entry   (ent[i]),
      .tok_out (tok_chain[i+1])
    );
  end

  always_comb begin
    cmd             = '0;
    cmd.mode        = SH_HOLD;
    cmd.fill.start  = pos[OFFSET_W-1:0];
    cmd.fill.length = req_q.request_bytes;
    cmd.append      = !tok_last.found;
    if (state == S_SCAN && tok_last.valid) begin
      if (req_q.operation == OP_FREE) begin
        if (tok_last.found) begin
          cmd.mode = SH_REMOVE;
        end
      end else if (!no_space) begin
        cmd.mode = SH_INSERT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      launch     <= '0;
      response   <= '0;
      check_step <= 1'b0;
    end else begin
      done         <= 1'b0;
      launch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q      <= request;
            check_step <= 1'b0;
            unique case (request.operation)
              OP_ALLOC: begin
                state <= S_CHECK;
              end
              OP_FREE: begin
                launch.valid <= 1'b1;
                state        <= S_SCAN;
              end
              OP_CLEAR: begin
                count    <= '0;
                done     <= 1'b1;
                response <= '{status: ST_OK, chunk_offset: '0};
              end
              default: begin
                done     <= 1'b1;
                response <= '{status: ST_OK, chunk_offset: '0};
              end
            endcase
          end
        end
        S_CHECK: begin
          if (!check_step) begin
            quot       <= prod[QS +: REQ_W];
            check_step <= 1'b1;
          end else if (req_q.request_bytes == '0 || quot_back != req_q.request_bytes) begin
            done     <= 1'b1;
            response <= '{status: ST_BAD_SIZE, chunk_offset: '0};
            state    <= S_IDLE;
          end else if (count == CW'(MAX_CHUNKS)) begin
            done     <= 1'b1;
            response <= '{status: ST_TABLE_FULL, chunk_offset: '0};
            state    <= S_IDLE;
          end else begin
            launch.valid <= 1'b1;
            state        <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_last.valid) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (req_q.operation == OP_FREE) begin
              if (tok_last.found) begin
                count    <= count - CW'(1);
                response <= '{status: ST_OK, chunk_offset: '0};
              end else begin
                response <= '{status: ST_NOT_FOUND, chunk_offset: '0};
              end
            end else if (no_space) begin
              response <= '{status: ST_NO_SPACE, chunk_offset: '0};
            end else begin
              count    <= count + CW'(1);
              response <= '{status: ST_OK, chunk_offset: pos[OFFSET_W-1:0]};
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/ffca_cell.sv @@
// ----------------------------------------------------------------------------
// ffca_cell
// One table slot: holds a chunk entry, tests it as the search token passes,
// and shifts with its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module ffca_cell #(
  parameter int IDX        = 0,
  parameter int MAX_CHUNKS = ffca_pkg::MAX_CHUNKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_CHUNKS+1)-1:0]     count,
  input  ffca_pkg::req_t                      request,
  input  ffca_pkg::cmd_t                      cmd,
  input  ffca_pkg::entry_t                    lower,
  input  ffca_pkg::entry_t                    upper,
  input  ffca_pkg::tok_t                      tok_in,
  output ffca_pkg::entry_t                    entry,
  output ffca_pkg::tok_t                      tok_out
);
  import ffca_pkg::*;

  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [CW-1:0] IDX_N = CW'(IDX + 1);

  logic             past_hit;
  logic             here;
  logic [END_W-1:0] chunk_end;
  logic [END_W-1:0] lower_end;
  logic [END_W:0]   need;
  logic             claim;
  tok_t             tok_next;

  assign chunk_end = END_W'(entry.start) + END_W'(entry.length);
  assign lower_end = END_W'(lower.start) + END_W'(lower.length);
  assign need      = (END_W+1)'(lower_end) + (END_W+1)'(request.request_bytes);

  // An allocate claims the slot whose gap below it, after the lower neighbor,
  // fits the request; the new chunk then takes this slot.
  always_comb begin
    claim = 1'b0;
    if (!tok_in.found) begin
      if (request.operation == OP_FREE) begin
        claim = (count > IDX_C) && (entry.start == request.free_offset);
      end else begin
        claim = (IDX_C != '0) && (count > IDX_C) && ((END_W+1)'(entry.start) >= need);
      end
    end
    tok_next       = tok_in;
    tok_next.found = tok_in.found | claim;
    if (claim) begin
      tok_next.pos = lower_end;
    end
    if (count == IDX_N) begin
      tok_next.tail = chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= '0;
      past_hit <= 1'b0;
      here     <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.valid) begin
        past_hit <= tok_in.found;
        here     <= claim;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.mode)
      SH_INSERT: begin
        if (past_hit) begin
          entry <= lower;
        end else if (here || (cmd.append && count == IDX_C)) begin
          entry <= cmd.fill;
        end
      end
      SH_REMOVE: begin
        if (past_hit || here) begin
          entry <= upper;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/ffca_checker.sv @@
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks on the allocator's request and result transfers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffca_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input ffca_pkg::req_t request,
  input ffca_pkg::rsp_t response
);
  import ffca_pkg::*;

  logic quick_op;

  assign quick_op = start && !busy &&
                    (request.operation == OP_CLEAR || request.operation == OP_NONE);

  `ASSERT_NXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  `ASSERT_IMP(a_done_has_cause, clk, rst, done, $past(start && !busy) || $past(busy))
  `ASSERT_IMP(a_fail_no_offset, clk, rst, done && response.status != ST_OK, response.chunk_offset == '0)
  `ASSERT_IMP(a_status_range, clk, rst, done, response.status <= ST_NOT_FOUND)
  `ASSERT_NXT(a_nonalloc_offset, clk, rst, quick_op, done && response.chunk_offset == '0)

endmodule

bind first_fit_chunk_allocator_core ffca_checker u_ffca_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .request  (request),
  .response (response)
);
